FILE: src/tls_pkg.sv
package tls_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W        = 16;
  localparam int PCT_W          = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int MEAS_WIDTH_DEF = 16;

  localparam logic [PCT_W-1:0] PCT_FULL = 10'd1000;

  // Register reset values
  localparam logic [FIELD_W-1:0] EMPTY_RST    = 16'd2000;
  localparam logic [FIELD_W-1:0] FULL_RST     = 16'd200;
  localparam logic [FIELD_W-1:0] HEIGHT_RST   = 16'd1800;
  localparam logic [FIELD_W-1:0] VOLUME_RST   = 16'd10000;
  localparam logic [PCT_W-1:0]   LOW_PCT_RST  = 10'd200;
  localparam logic [PCT_W-1:0]   HIGH_PCT_RST = 10'd900;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY    = 3'd0,
    CFG_FULL     = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_VOLUME   = 3'd3,
    CFG_ALERTS   = 3'd4,
    CFG_LOW_PCT  = 3'd5,
    CFG_HIGH_PCT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } top_st_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_PREP,
    PH_DIV
  } lane_ph_e;

  typedef struct packed {
    logic             enabled;
    logic [PCT_W-1:0] low_thr;
    logic [PCT_W-1:0] high_thr;
  } alarm_cfg_t;

  typedef struct packed {
    logic low_ev;
    logic high_ev;
    logic low_on;
    logic high_on;
  } alarm_stat_t;

endpackage

FILE: src/tls_ifs.sv
interface tls_in_if;
  logic                         valid;
  logic                         ready;
  logic [tls_pkg::FIELD_W-1:0]  distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface tls_out_if;
  logic                         valid;
  logic                         ready;
  logic [tls_pkg::PCT_W-1:0]    fill_pct;
  logic [tls_pkg::FIELD_W-1:0]  water_height;
  logic [tls_pkg::FIELD_W-1:0]  water_volume;
  logic                         low_alarm_event;
  logic                         high_alarm_event;
  logic                         low_alarm_on;
  logic                         high_alarm_on;

  modport source (output valid, output fill_pct, output water_height, output water_volume,
                  output low_alarm_event, output high_alarm_event,
                  output low_alarm_on, output high_alarm_on, input ready);
  modport sink   (input valid, input fill_pct, input water_height, input water_volume,
                  input low_alarm_event, input high_alarm_event,
                  input low_alarm_on, input high_alarm_on, output ready);
endinterface

interface tls_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tls_pkg::CFG_IDX_W-1:0]  index;
  logic [tls_pkg::FIELD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/tls_muldiv.sv
// Bit-serial lane: round(scale * num / (2 * den) * 2) as floor((2*scale*num + den) / (2*den)).
// Shift-add multiply one bit a cycle, then restoring divide one quotient bit a cycle.
module tls_muldiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tls_pkg::FIELD_W-1:0]  scale_i,
  input  logic [tls_pkg::FIELD_W-1:0]  num_i,
  input  logic [tls_pkg::FIELD_W-1:0]  den_i,
  output logic                         done_o,
  output logic [tls_pkg::FIELD_W-1:0]  quot_o
);
  import tls_pkg::*;

  localparam int W     = FIELD_W;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

  lane_ph_e ph_q, ph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic [W-1:0] scale_q, scale_d;
  logic [W-1:0] den_q, den_d;
  logic [W-1:0] hi_q, hi_d;
  logic [W-1:0] lo_q, lo_d;
  logic [W:0]   rem_q, rem_d;

  logic [W:0]   mul_sum;
  logic [2*W:0] dividend;
  logic [W+1:0] rem_sh;
  logic [W+1:0] rem_diff;
  logic         qbit;

  // Datapath terms for the current step
  always_comb begin
    mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, scale_q} : '0);
    dividend = {hi_q, lo_q, 1'b0} + {{(W+1){1'b0}}, den_q};
    rem_sh   = {rem_q, hi_q[W-1]};
    rem_diff = rem_sh - {1'b0, den_q, 1'b0};
    qbit     = (rem_sh >= {1'b0, den_q, 1'b0});
  end

  // Hold state and phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    den_q   <= den_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    rem_q   <= rem_d;
  end

  // Sequence multiply, prepare, divide
  always_comb begin
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    scale_d = scale_q;
    den_d   = den_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    rem_d   = rem_q;
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          ph_d    = PH_MUL;
          cnt_d   = '0;
          done_d  = 1'b0;
          scale_d = scale_i;
          den_d   = den_i;
          hi_d    = '0;
          lo_d    = num_i;
        end
      end
      PH_MUL: begin
        // Add scale on a set multiplier bit, shift product right
        hi_d  = mul_sum[W:1];
        lo_d  = {mul_sum[0], lo_q[W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          ph_d = PH_PREP;
        end
      end
      PH_PREP: begin
        // Upper part of the dividend seeds the remainder, low part is shifted in
        rem_d = dividend[2*W:W];
        hi_d  = dividend[W-1:0];
        lo_d  = '0;
        cnt_d = '0;
        ph_d  = PH_DIV;
      end
      PH_DIV: begin
        rem_d = qbit ? rem_diff[W:0] : rem_sh[W:0];
        hi_d  = {hi_q[W-2:0], 1'b0};
        lo_d  = {lo_q[W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          ph_d   = PH_IDLE;
          done_d = 1'b1;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

FILE: src/tls_alarm.sv
// Low and high alarm latches with one-shot events
module tls_alarm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        update_i,
  input  logic [tls_pkg::PCT_W-1:0]   pct_i,
  input  tls_pkg::alarm_cfg_t         cfg_i,
  output tls_pkg::alarm_stat_t        stat_o
);
  import tls_pkg::*;

  logic low_latch_q, low_latch_d;
  logic high_latch_q, high_latch_d;

  // Compare the fill level with inclusive thresholds
  always_comb begin
    stat_o.low_on  = cfg_i.enabled && (pct_i <= cfg_i.low_thr);
    stat_o.high_on = cfg_i.enabled && (pct_i >= cfg_i.high_thr);
    stat_o.low_ev  = stat_o.low_on && !low_latch_q;
    stat_o.high_ev = stat_o.high_on && !high_latch_q;
    low_latch_d    = update_i ? stat_o.low_on : low_latch_q;
    high_latch_d   = update_i ? stat_o.high_on : high_latch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_latch_q  <= 1'b0;
      high_latch_q <= 1'b0;
    end else begin
      low_latch_q  <= low_latch_d;
      high_latch_q <= high_latch_d;
    end
  end

  a_low_ev_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && stat_o.low_ev) |=> (low_latch_q && !stat_o.low_ev))
    else $error("low alarm event did not set its latch");

  a_high_ev_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && stat_o.high_ev) |=> (high_latch_q && !stat_o.high_ev))
    else $error("high alarm event did not set its latch");

  a_disabled_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && !cfg_i.enabled) |=> (!low_latch_q && !high_latch_q))
    else $error("alarm latch survived with alerts disabled");

endmodule

FILE: src/tank_level_scaler_alerts.sv
// Tank level scaler with latched level alarms.
// Channels: in_i takes one distance sample per beat; out_o returns one result beat
// (fill level, height, volume, alarm events and alarm flags); cfg_i writes one
// register per beat by index and is always ready. Write configuration only while idle.
// A zero distance is dropped and gives no result. Samples beyond the empty distance,
// nearer than the full distance, or on a zero range are clamped: the clamped result
// is registered and loaded into the output register from the finish state, and the
// next sample is taken once the sequencer is idle again. Samples inside the range run
// three bit-serial multiply-divide lanes side by side: 16 multiply steps, 1 prepare
// step and 16 divide steps, then the quotients are captured and loaded into the
// output register. One item is processed at a time; in_i is ready only while idle.
// The result sits in an output register: the next sample is taken while it waits,
// and if out_o is stalled the following result holds until the register frees.
// Reset restores the register defaults and clears both alarm latches.
module tank_level_scaler_alerts #(
  parameter int MEAS_WIDTH = tls_pkg::MEAS_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tls_in_if.sink     in_i,
  tls_out_if.source  out_o,
  tls_cfg_if.sink    cfg_i
);
  import tls_pkg::*;

  localparam int DW = (MEAS_WIDTH < FIELD_W) ? MEAS_WIDTH : FIELD_W;
  localparam logic [FIELD_W-1:0] MEAS_MASK = FIELD_W'((17'd1 << DW) - 17'd1);

  top_st_e st_q, st_d;

  logic [FIELD_W-1:0] empty_q, full_q, height_q, volume_q;
  logic               alerts_q;
  logic [PCT_W-1:0]   low_thr_q, high_thr_q;

  logic [PCT_W-1:0]   res_pct_q;
  logic [FIELD_W-1:0] res_h_q, res_v_q;

  logic               out_valid_q, out_valid_d;
  logic [PCT_W-1:0]   out_pct_q;
  logic [FIELD_W-1:0] out_h_q, out_v_q;
  alarm_stat_t        out_stat_q;

  logic [FIELD_W-1:0] meas;
  logic               in_beat, item_beat;
  logic               beyond, nearer, clamp;
  logic               lane_start, lanes_done, load;
  logic [FIELD_W-1:0] num, den;
  logic [FIELD_W-1:0] q_pct, q_h, q_v;
  logic               done_pct, done_h, done_v;
  alarm_cfg_t         alarm_cfg;
  alarm_stat_t        alarm_stat;

  // Classify the sample
  always_comb begin
    meas      = in_i.distance & MEAS_MASK;
    in_beat   = in_i.valid && in_i.ready;
    item_beat = in_beat && (meas != '0);
    beyond    = meas > empty_q;
    nearer    = meas < full_q;
    clamp     = beyond || nearer || (empty_q == full_q);
    num       = empty_q - meas;
    den       = empty_q - full_q;
  end

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q    <= EMPTY_RST & MEAS_MASK;
      full_q     <= FULL_RST & MEAS_MASK;
      height_q   <= HEIGHT_RST;
      volume_q   <= VOLUME_RST;
      alerts_q   <= 1'b1;
      low_thr_q  <= LOW_PCT_RST;
      high_thr_q <= HIGH_PCT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_EMPTY:    empty_q    <= cfg_i.data & MEAS_MASK;
        CFG_FULL:     full_q     <= cfg_i.data & MEAS_MASK;
        CFG_HEIGHT:   height_q   <= cfg_i.data;
        CFG_VOLUME:   volume_q   <= cfg_i.data;
        CFG_ALERTS:   alerts_q   <= cfg_i.data[0];
        CFG_LOW_PCT:  low_thr_q  <= cfg_i.data[PCT_W-1:0];
        CFG_HIGH_PCT: high_thr_q <= cfg_i.data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Three scaling lanes sharing numerator and denominator
  tls_muldiv u_lane_pct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .scale_i ({{(FIELD_W-PCT_W){1'b0}}, PCT_FULL}),
    .num_i   (num),
    .den_i   (den),
    .done_o  (done_pct),
    .quot_o  (q_pct)
  );

  tls_muldiv u_lane_height (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .scale_i (height_q),
    .num_i   (num),
    .den_i   (den),
    .done_o  (done_h),
    .quot_o  (q_h)
  );

  tls_muldiv u_lane_volume (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .scale_i (volume_q),
    .num_i   (num),
    .den_i   (den),
    .done_o  (done_v),
    .quot_o  (q_v)
  );

  assign lanes_done = done_pct && done_h && done_v;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    in_i.ready = 1'b0;
    lane_start = 1'b0;
    load       = 1'b0;
    case (st_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (item_beat) begin
          if (clamp) begin
            st_d = ST_FINISH;
          end else begin
            lane_start = 1'b1;
            st_d       = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (lanes_done) begin
          st_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Capture clamped values or lane quotients
  always_ff @(posedge clk_i) begin
    if (item_beat && clamp) begin
      if (nearer && !beyond) begin
        res_pct_q <= PCT_FULL;
        res_h_q   <= height_q;
        res_v_q   <= volume_q;
      end else begin
        res_pct_q <= '0;
        res_h_q   <= '0;
        res_v_q   <= '0;
      end
    end else if (st_q == ST_CALC && lanes_done) begin
      res_pct_q <= q_pct[PCT_W-1:0];
      res_h_q   <= q_h;
      res_v_q   <= q_v;
    end
  end

  // Alarms
  assign alarm_cfg = '{enabled: alerts_q, low_thr: low_thr_q, high_thr: high_thr_q};

  tls_alarm u_alarm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (load),
    .pct_i    (res_pct_q),
    .cfg_i    (alarm_cfg),
    .stat_o   (alarm_stat)
  );

  // Output register: load on a free slot, drop on a taken beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pct_q  <= res_pct_q;
      out_h_q    <= res_h_q;
      out_v_q    <= res_v_q;
      out_stat_q <= alarm_stat;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.fill_pct         = out_pct_q;
  assign out_o.water_height     = out_h_q;
  assign out_o.water_volume     = out_v_q;
  assign out_o.low_alarm_event  = out_stat_q.low_ev;
  assign out_o.high_alarm_event = out_stat_q.high_ev;
  assign out_o.low_alarm_on     = out_stat_q.low_on;
  assign out_o.high_alarm_on    = out_stat_q.high_on;

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_pct == done_h) && (done_h == done_v))
    else $error("scaling lanes out of step");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CALC && lanes_done) |-> (q_pct <= {{(FIELD_W-PCT_W){1'b0}}, PCT_FULL}))
    else $error("fill level above full scale");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !load)
    else $error("result loaded over a stalled beat");

endmodule
